// ----- rtl/core/icpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - shared definitions
// Types, constants and codes used by the parser, the queue and the result
// stage.
// ----------------------------------------------------------------------------
package icpr_pkg;

  localparam int MAX_PACKET_BYTES = 65535;
  localparam int OFF_W            = $clog2(MAX_PACKET_BYTES + 1);

  // Offset of the id low byte inside the packet; at most 132, 0 = unknown.
  localparam int FIELD_BASE_W = 8;

  // Depth of the result queue between parser and result stage (power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] IP_PROTO_ICMP           = 8'd1;
  localparam logic [7:0] ICMP_TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [3:0] MIN_HEADER_WORDS        = 4'd5;

  // Fixed byte offsets in the outer IPv4 header.
  localparam logic [OFF_W-1:0] OFF_PROTOCOL = OFF_W'(9);
  localparam logic [OFF_W-1:0] OFF_SRC_FIRST = OFF_W'(12);
  localparam logic [OFF_W-1:0] OFF_SRC_LAST  = OFF_W'(15);

  typedef enum logic [1:0] {
    KIND_OTHER         = 2'd0,
    KIND_ECHO          = 2'd1,
    KIND_TIME_EXCEEDED = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_EXPECTED_ID = 1'b0,
    CFG_PROBE_TTL   = 1'b1
  } cfg_reg_t;

  // What the parser hands over at the last byte of a packet.
  typedef struct packed {
    logic        complete;
    kind_t       kind;
    logic [15:0] id;
    logic [15:0] seq;
    logic [31:0] addr;
  } reply_rec_t;

endpackage

// ----- rtl/core/icpr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - packet parser
// Walks the packet one byte per item, captures the source address, the
// ICMP kind and the id and sequence bytes, and emits a record at the last
// byte.
// ----------------------------------------------------------------------------
module icpr_parser import icpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] packet_byte,
  input  logic       last_byte,
  input  logic       queue_full,
  output logic       rec_push,
  output reply_rec_t rec
);

  logic [OFF_W-1:0]        byte_offset;
  logic [3:0]              outer_header_words;
  logic                    protocol_is_icmp;
  kind_t                   kind_seen;
  logic [FIELD_BASE_W-1:0] echo_field_base;
  logic [15:0]             captured_id;
  logic [15:0]             captured_seq;
  logic [31:0]             source_addr;

  logic [OFF_W-1:0]        byte_offset_next;
  logic [3:0]              outer_header_words_next;
  logic                    protocol_is_icmp_next;
  kind_t                   kind_seen_next;
  logic [FIELD_BASE_W-1:0] echo_field_base_next;
  logic [15:0]             captured_id_next;
  logic [15:0]             captured_seq_next;
  logic [31:0]             source_addr_next;

  logic                    accept;
  logic                    active;
  logic [5:0]              base;
  logic [OFF_W-1:0]        field_end;
  logic [OFF_W-1:0]        field_rel;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign active   = byte_offset < OFF_W'(MAX_PACKET_BYTES);

  always_comb begin
    outer_header_words_next = outer_header_words;
    protocol_is_icmp_next   = protocol_is_icmp;
    kind_seen_next          = kind_seen;
    echo_field_base_next    = echo_field_base;
    captured_id_next        = captured_id;
    captured_seq_next       = captured_seq;
    source_addr_next        = source_addr;
    byte_offset_next        = byte_offset;
    base                    = {outer_header_words_next, 2'b00};
    field_end               = '0;
    field_rel               = '0;
    if (active) begin
      if (byte_offset == '0) begin
        outer_header_words_next = packet_byte[3:0];
        protocol_is_icmp_next   = 1'b0;
        kind_seen_next          = KIND_OTHER;
        echo_field_base_next    = '0;
        captured_id_next        = '0;
        captured_seq_next       = '0;
        source_addr_next        = '0;
      end
      if (byte_offset == OFF_PROTOCOL) begin
        protocol_is_icmp_next = (packet_byte == IP_PROTO_ICMP);
      end
      if (byte_offset >= OFF_SRC_FIRST && byte_offset <= OFF_SRC_LAST) begin
        source_addr_next = {source_addr_next[23:0], packet_byte};
      end
      base = {outer_header_words_next, 2'b00};
      if (outer_header_words_next >= MIN_HEADER_WORDS) begin
        if (byte_offset == OFF_W'(base) && protocol_is_icmp_next) begin
          if (packet_byte == ICMP_TYPE_ECHO_REPLY) begin
            kind_seen_next       = KIND_ECHO;
            echo_field_base_next = FIELD_BASE_W'(base) + FIELD_BASE_W'(4);
          end else if (packet_byte == ICMP_TYPE_TIME_EXCEEDED) begin
            kind_seen_next = KIND_TIME_EXCEEDED;
          end
        end
        // The inner header's own length nibble locates the embedded ICMP header.
        if (byte_offset == OFF_W'(base) + OFF_W'(8) &&
            kind_seen_next == KIND_TIME_EXCEEDED) begin
          echo_field_base_next = FIELD_BASE_W'(base) + FIELD_BASE_W'(12) +
                                 FIELD_BASE_W'({packet_byte[3:0], 2'b00});
        end
      end
      field_end = OFF_W'(echo_field_base_next) + OFF_W'(4);
      field_rel = byte_offset - OFF_W'(echo_field_base_next);
      if (echo_field_base_next != '0 &&
          byte_offset >= OFF_W'(echo_field_base_next) && byte_offset < field_end) begin
        unique case (field_rel[1:0])
          2'd0:    captured_id_next  = {captured_id_next[15:8], packet_byte};
          2'd1:    captured_id_next  = {packet_byte, captured_id_next[7:0]};
          2'd2:    captured_seq_next = {captured_seq_next[15:8], packet_byte};
          default: captured_seq_next = {packet_byte, captured_seq_next[7:0]};
        endcase
      end
      byte_offset_next = byte_offset + OFF_W'(1);
    end
  end

  assign rec_push      = accept && last_byte;
  assign rec.complete  = (echo_field_base_next != '0) &&
                         (byte_offset_next >= OFF_W'(echo_field_base_next) + OFF_W'(4));
  assign rec.kind      = kind_seen_next;
  assign rec.id        = captured_id_next;
  assign rec.seq       = captured_seq_next;
  assign rec.addr      = source_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset        <= '0;
      outer_header_words <= '0;
      protocol_is_icmp   <= 1'b0;
      kind_seen          <= KIND_OTHER;
      echo_field_base    <= '0;
      captured_id        <= '0;
      captured_seq       <= '0;
      source_addr        <= '0;
    end else if (accept) begin
      byte_offset        <= last_byte ? '0 : byte_offset_next;
      outer_header_words <= outer_header_words_next;
      protocol_is_icmp   <= protocol_is_icmp_next;
      kind_seen          <= kind_seen_next;
      echo_field_base    <= echo_field_base_next;
      captured_id        <= captured_id_next;
      captured_seq       <= captured_seq_next;
      source_addr        <= source_addr_next;
    end
  end

`ifndef ASSERT_OFF
  // A known field position is only ever set together with a recognised kind.
  a_base_needs_kind: assert property (@(posedge clk) disable iff (rst)
    echo_field_base != '0 |-> kind_seen != KIND_OTHER)
    else $error("field position known without a recognised ICMP kind");
`endif

endmodule

// ----- rtl/core/icpr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - record queue
// Short first-in first-out queue that decouples the parser from the result
// stage.
// ----------------------------------------------------------------------------
module icpr_queue import icpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  reply_rec_t push_rec,
  output logic       full,
  output logic       not_empty,
  input  logic       pop,
  output reply_rec_t pop_rec
);

  reply_rec_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_CW-1:0]    count;

  assign full      = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop)
    else $error("record popped from an empty queue");
`endif

endmodule

// ----- rtl/core/icpr_result.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - result stage
// Takes one parsed record, decides the match against the configured id and
// TTL, works out the probe index and holds the result until it is taken.
// ----------------------------------------------------------------------------
module icpr_result import icpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rec_valid,
  input  reply_rec_t  rec,
  output logic        rec_pop,
  input  logic [7:0]  expected_id,
  input  logic [4:0]  probe_ttl,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic [1:0]  reply_kind,
  output logic [1:0]  probe_index,
  output logic [31:0] responder_addr,
  output logic [15:0] reply_seq
);

  // Residue modulo three: four is one modulo three, so the two-bit digits
  // are summed and the small sum is folded once more.
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [15:0] seq;
  logic [6:0]  ttl_times3;
  logic [16:0] seq_minus;
  logic        ttl_hit;
  logic        match_now;

  assign seq        = rec.complete ? rec.seq : '0;
  assign ttl_times3 = {1'b0, probe_ttl, 1'b0} + 7'(probe_ttl);
  assign seq_minus  = {1'b0, seq} - 17'(ttl_times3);
  // seq / 3 equals the TTL exactly when seq lies in [3*ttl, 3*ttl + 2].
  assign ttl_hit    = !seq_minus[16] && (seq_minus[15:0] <= 16'd2);
  assign match_now  = rec.complete && (rec.kind != KIND_OTHER) &&
                      (rec.id == {8'h00, expected_id}) && ttl_hit;

  assign rec_pop = rec_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      matched        <= match_now;
      reply_kind     <= rec.kind;
      probe_index    <= mod3_16(seq);
      responder_addr <= rec.addr;
      reply_seq      <= seq;
    end
  end

`ifndef ASSERT_OFF
  a_match_has_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> reply_kind != KIND_OTHER)
    else $error("match reported for a reply of no known kind");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> probe_index != 2'd3)
    else $error("probe index out of range");
`endif

endmodule

// ----- rtl/core/icmp_probe_reply_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - top level
// Matches received IPv4 packets against the current round of traceroute
// probes.
// ----------------------------------------------------------------------------
// Usage:
// Packet bytes enter on the input channel (in_valid, in_ready, packet_byte,
// last_byte), one item per byte; last_byte marks the final byte of a packet.
// One result item per packet leaves on the output channel (out_valid,
// out_ready) carrying matched, reply_kind, probe_index, responder_addr and
// reply_seq. The cfg channel writes expected_id (index 0) and probe_ttl
// (index 1); cfg_ready is always high and writes belong to idle periods.
// Throughput is one byte per cycle while the queue is not full. The parser
// hands the record of a packet to a four-entry queue when its last byte is
// accepted, and the result stage registers it from there once its output
// is free.
// If the receiver stalls, up to four results wait in the queue besides the
// one on the outputs; in_ready then drops until a result is taken.
// Reset (rst, synchronous) empties the queue, clears out_valid and the
// parse state, and sets expected_id to 0 and probe_ttl to 1.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier import icpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic [1:0]  reply_kind,
  output logic [1:0]  probe_index,
  output logic [31:0] responder_addr,
  output logic [15:0] reply_seq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] expected_id;
  logic [4:0] probe_ttl;

  logic       queue_full;
  logic       queue_not_empty;
  logic       rec_push;
  logic       rec_pop;
  reply_rec_t push_rec;
  reply_rec_t pop_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 8'd0;
      probe_ttl   <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EXPECTED_ID: expected_id <= cfg_data;
        CFG_PROBE_TTL:   probe_ttl   <= cfg_data[4:0];
        default:         ;
      endcase
    end
  end

  icpr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .queue_full  (queue_full),
    .rec_push    (rec_push),
    .rec         (push_rec)
  );

  icpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_rec  (push_rec),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (rec_pop),
    .pop_rec   (pop_rec)
  );

  icpr_result u_result (
    .clk            (clk),
    .rst            (rst),
    .rec_valid      (queue_not_empty),
    .rec            (pop_rec),
    .rec_pop        (rec_pop),
    .expected_id    (expected_id),
    .probe_ttl      (probe_ttl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .matched        (matched),
    .reply_kind     (reply_kind),
    .probe_index    (probe_index),
    .responder_addr (responder_addr),
    .reply_seq      (reply_seq)
  );

endmodule

// ----- dv/icmp_probe_reply_classifier_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP probe reply classifier - block level regression
// Streams IPv4 packets into the classifier one byte per item. Directed
// packets come first, then random echo replies, time-exceeded messages,
// truncated and malformed packets. A tracker class predicts the result of
// every packet, and each result item is checked field by field against the
// oldest prediction. The sender idles in bursts, the receiver stalls on its
// own pattern, and one long receiver hold-off fills the result queue.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier_test;
  import icpr_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  class reply_tracker;
    typedef struct {
      logic        matched;
      logic [1:0]  kind;
      logic [1:0]  idx;
      logic [31:0] addr;
      logic [15:0] seq;
    } verdict_t;

    logic [7:0]  expected_id;
    logic [4:0]  probe_ttl;
    int unsigned offset;
    logic [3:0]  hdr_words;
    bit          is_icmp;
    kind_t       kind_seen;
    int unsigned id_base;
    logic [15:0] cap_id;
    logic [15:0] cap_seq;
    logic [31:0] src_addr;
    verdict_t    pending_verdicts[$];
    int          errors;
    int          shown;

    function new();
      expected_id = 8'd0;
      probe_ttl   = 5'd1;
      errors      = 0;
      shown       = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      offset    = 0;
      hdr_words = 4'd0;
      is_icmp   = 1'b0;
      kind_seen = KIND_OTHER;
      id_base   = 0;
      cap_id    = 16'd0;
      cap_seq   = 16'd0;
      src_addr  = 32'd0;
    endfunction

    function void set_register(cfg_reg_t reg_idx, logic [7:0] data);
      if (reg_idx == CFG_EXPECTED_ID) expected_id = data;
      else probe_ttl = data[4:0];
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Advances the parse by one accepted byte; a byte marked last closes the
    // packet and queues its predicted result.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned o;
      int unsigned hdr_base;
      logic        complete;
      logic [15:0] seq_val;
      verdict_t    v;
      o = offset;
      if (o < MAX_PACKET_BYTES) begin
        if (o == 0) begin
          clear_packet();
          hdr_words = b[3:0];
        end
        if (o == 9) is_icmp = (b == IP_PROTO_ICMP);
        if (o >= 12 && o <= 15) src_addr = {src_addr[23:0], b};
        if (hdr_words >= MIN_HEADER_WORDS) begin
          hdr_base = 4 * hdr_words;
          if (o == hdr_base && is_icmp) begin
            if (b == ICMP_TYPE_ECHO_REPLY) begin
              kind_seen = KIND_ECHO;
              id_base   = hdr_base + 4;
            end else if (b == ICMP_TYPE_TIME_EXCEEDED) begin
              kind_seen = KIND_TIME_EXCEEDED;
            end
          end
          // The embedded header length decides where the inner ICMP id sits.
          if (o == hdr_base + 8 && kind_seen == KIND_TIME_EXCEEDED)
            id_base = hdr_base + 12 + 4 * b[3:0];
        end
        if (id_base != 0 && o >= id_base && o < id_base + 4) begin
          case (o - id_base)
            0: cap_id[7:0] = b;
            1: cap_id[15:8] = b;
            2: cap_seq[7:0] = b;
            default: cap_seq[15:8] = b;
          endcase
        end
        offset = o + 1;
      end
      if (last) begin
        complete  = (id_base != 0) && (offset >= id_base + 4);
        seq_val   = complete ? cap_seq : 16'd0;
        v.matched = complete && (kind_seen != KIND_OTHER) &&
                    (cap_id == {8'h00, expected_id}) && ((seq_val / 3) == probe_ttl);
        v.kind    = kind_seen;
        v.idx     = 2'(seq_val % 3);
        v.addr    = src_addr;
        v.seq     = seq_val;
        pending_verdicts.push_back(v);
        offset = 0;
      end
    endfunction

    function void report(string msg);
      errors++;
      if (shown < 60) begin
        shown++;
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endfunction

    function void check_verdict(logic got_match, logic [1:0] got_kind, logic [1:0] got_idx,
                                logic [31:0] got_addr, logic [15:0] got_seq);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result with none expected (kind %0d seq %h)", got_kind, got_seq));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got_match !== want.matched)
        report($sformatf("matched %b, expected %b", got_match, want.matched));
      if (got_kind !== want.kind)
        report($sformatf("reply_kind %0d, expected %0d", got_kind, want.kind));
      if (got_idx !== want.idx)
        report($sformatf("probe_index %0d, expected %0d", got_idx, want.idx));
      if (got_addr !== want.addr)
        report($sformatf("responder_addr %h, expected %h", got_addr, want.addr));
      if (got_seq !== want.seq)
        report($sformatf("reply_seq %h, expected %h", got_seq, want.seq));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        matched;
  logic [1:0]  reply_kind;
  logic [1:0]  probe_index;
  logic [31:0] responder_addr;
  logic [15:0] reply_seq;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  reply_tracker tracker;
  logic [7:0]   frame_bytes[$];
  int           burst_left;
  int           items_sent;
  bit           gap_free;
  bit           long_hold_req;

  icmp_probe_reply_classifier u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: changes its stall pattern every so often; a hold-off request
  // keeps it stalled for a long stretch of its own counting.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int period;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    period    = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 80;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      period++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((period % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_verdict(matched, reply_kind, probe_index, responder_addr, reply_seq);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = gap_free ? 0 : $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    packet_byte <= b;
    last_byte   <= last;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame(input int cut);
    for (int i = 0; i < cut; i++) send_byte(frame_bytes[i], i == cut - 1);
  endtask

  task automatic write_reg(input cfg_reg_t reg_idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(reg_idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers may only change once the last result has left the block.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [15:0] own_id();
    return {8'h00, tracker.expected_id};
  endfunction

  function automatic logic [15:0] round_seq(input int probe);
    return 16'(3 * tracker.probe_ttl + probe);
  endfunction

  // Lays out an outer IPv4 header, the ICMP header and, for time exceeded,
  // the embedded IPv4 header and ICMP header that carry our id and sequence.
  function automatic void build_reply(input logic [3:0] ihl, input logic [3:0] inner_ihl,
                                      input logic [7:0] proto, input logic [7:0] msg_type,
                                      input logic [15:0] id_v, input logic [15:0] seq_v,
                                      input int tail_len);
    int hdr_len;
    hdr_len = (ihl >= MIN_HEADER_WORDS) ? 4 * ihl : 20;
    frame_bytes.delete();
    for (int i = 0; i < hdr_len; i++) frame_bytes.push_back(8'($urandom));
    frame_bytes[0] = {(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4), ihl};
    frame_bytes[9] = proto;
    frame_bytes.push_back(msg_type);
    for (int i = 0; i < 3; i++) frame_bytes.push_back(8'($urandom));
    if (msg_type == ICMP_TYPE_TIME_EXCEEDED) begin
      for (int i = 0; i < 4; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back({4'h4, inner_ihl});
      for (int i = 1; i < 4 * inner_ihl; i++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'd8);
      for (int i = 0; i < 3; i++) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(id_v[7:0]);
    frame_bytes.push_back(id_v[15:8]);
    frame_bytes.push_back(seq_v[7:0]);
    frame_bytes.push_back(seq_v[15:8]);
    for (int i = 0; i < tail_len; i++) frame_bytes.push_back(8'($urandom));
  endfunction

  // A cut of zero sends the whole packet.
  task automatic send_reply(input logic [3:0] ihl, input logic [3:0] inner_ihl,
                            input logic [7:0] proto, input logic [7:0] msg_type,
                            input logic [15:0] id_v, input logic [15:0] seq_v, input int cut);
    build_reply(ihl, inner_ihl, proto, msg_type, id_v, seq_v, $urandom_range(0, 4));
    send_frame((cut == 0) ? frame_bytes.size() : cut);
  endtask

  task automatic send_noise(input int len);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    send_frame(len);
  endtask

  task automatic random_packet();
    int          pick;
    int          r;
    int          cut;
    logic [3:0]  ihl;
    logic [3:0]  inner;
    logic [7:0]  proto;
    logic [7:0]  msg_type;
    logic [15:0] id_v;
    logic [15:0] seq_v;
    pick  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    inner = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd5;
    proto = IP_PROTO_ICMP;
    msg_type = $urandom_range(0, 1) ? ICMP_TYPE_ECHO_REPLY : ICMP_TYPE_TIME_EXCEEDED;
    id_v = own_id();
    r = $urandom_range(0, 9);
    if (r == 0) id_v[15:8] = 8'($urandom_range(1, 255));
    else if (r == 1) id_v = 16'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) seq_v = round_seq($urandom_range(0, 2));
    else if (r < 8) seq_v = 16'($urandom);
    else seq_v = round_seq($urandom_range(3, 5));
    if (pick < 10) ihl = 4'($urandom_range(0, 4));
    else if (pick < 18) proto = 8'($urandom);
    else if (pick < 26) msg_type = 8'($urandom);
    if (pick >= 90) begin
      send_noise($urandom_range(1, 40));
    end else begin
      build_reply(ihl, inner, proto, msg_type, id_v, seq_v, $urandom_range(0, 6));
      cut = frame_bytes.size();
      if (pick >= 26 && pick < 40) cut = $urandom_range(1, cut);
      send_frame(cut);
    end
  endtask

  task automatic apply_setting(input int phase);
    case (phase % 5)
      0: begin
        write_reg(CFG_EXPECTED_ID, 8'h00);
        write_reg(CFG_PROBE_TTL, 8'd1);
      end
      1: begin
        write_reg(CFG_EXPECTED_ID, 8'hFF);
        write_reg(CFG_PROBE_TTL, 8'd30);
      end
      2: begin
        write_reg(CFG_EXPECTED_ID, 8'($urandom));
        write_reg(CFG_PROBE_TTL, 8'($urandom));
      end
      3: begin
        write_reg(CFG_EXPECTED_ID, 8'($urandom));
        write_reg(CFG_PROBE_TTL, {3'b111, 5'd31});
      end
      default: begin
        write_reg(CFG_EXPECTED_ID, 8'($urandom));
        write_reg(CFG_PROBE_TTL, 8'd0);
      end
    endcase
  endtask

  initial begin
    int pkt_count;
    int phase;
    int byte_goal;
    tracker       = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    packet_byte   = 8'd0;
    last_byte     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_EXPECTED_ID;
    cfg_data      = 8'd0;
    burst_left    = 0;
    items_sent    = 0;
    gap_free      = 1'b0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets: a match under the reset settings first.
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 0);
    wait_idle();
    write_reg(CFG_EXPECTED_ID, 8'hA5);
    write_reg(CFG_PROBE_TTL, 8'd12);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_TIME_EXCEEDED, own_id(), round_seq(1), 0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(2), 0);
    send_reply(4'd15, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(1), 0);
    send_reply(4'd15, 4'd15, IP_PROTO_ICMP, ICMP_TYPE_TIME_EXCEEDED, own_id(), round_seq(2), 0);
    send_reply(4'd4, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 0);
    send_reply(4'd0, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 0);
    send_reply(4'd5, 4'd5, 8'd6, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, 8'd3, own_id(), round_seq(0), 0);
    // Cut short just before the sequence high byte.
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(0), 27);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_TIME_EXCEEDED, own_id(), round_seq(0), 40);
    send_noise(1);
    send_noise(14);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, {8'h01, 8'hA5}, round_seq(0), 0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), 16'hFFFF, 0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_TIME_EXCEEDED, own_id(), round_seq(3), 0);
    wait_idle();
    write_reg(CFG_PROBE_TTL, 8'd0);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, own_id(), round_seq(1), 0);
    wait_idle();
    write_reg(CFG_PROBE_TTL, 8'hFF);
    send_reply(4'd5, 4'd5, IP_PROTO_ICMP, ICMP_TYPE_TIME_EXCEEDED, own_id(), round_seq(2), 0);

    // Random part until the item budget is spent, with the settings changed
    // between small groups of packets.
    byte_goal = 1050;
    pkt_count = 0;
    phase     = 0;
    while (items_sent < byte_goal) begin
      if (pkt_count % 3 == 0) begin
        wait_idle();
        apply_setting(phase);
        phase++;
      end
      if (pkt_count == 1) begin
        // Receiver holds off while short packets keep coming back to back.
        long_hold_req = 1'b1;
        gap_free      = 1'b1;
        repeat (16) send_noise($urandom_range(1, 3));
        gap_free = 1'b0;
      end
      random_packet();
      pkt_count++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
